FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the calendar converter.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdcd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SDCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdcd check failed");

`endif

FILE: rtl/sdcd_pkg.sv
// Package of the serial day to calendar date converter: types, microcode codes,
// constants and small arithmetic helpers. Depends on nothing.
`timescale 1ns / 1ps

package sdcd_pkg;

    typedef struct packed {
        logic [21:0] day_count;
        logic [16:0] second_of_day;
    } t_item;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_result;

    // Datapath operations selected by a control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_MULY,   // year product = day * reciprocal of 365.2425
        OP_YEST,   // year estimate from the product
        OP_REMA,   // rem = day - days of whole years, century of year-1
        OP_REMB,   // rem -= leap days before the year
        OP_YDEC,   // step year down
        OP_CENT,   // century of the current year
        OP_YADD,   // rem += length of year
        OP_YSUB,   // rem -= length of year, step year up
        OP_HOUR,   // hour quotient, month reset to January
        OP_MS1,    // seconds left after the hours
        OP_MS2,    // minute quotient
        OP_MS3,    // seconds left after the minutes
        OP_MSUB,   // rem -= month length, advance month
        OP_DONE    // capture result
    } t_op;

    // Jump conditions.
    typedef enum logic [1:0] {
        C_NONE,
        C_REM_POS,
        C_REM_FITS,
        C_MON_DONE
    } t_cond;

    typedef logic [3:0] t_addr;

    // Program labels.
    localparam t_addr ST_MULY  = 4'd0;
    localparam t_addr ST_YEST  = 4'd1;
    localparam t_addr ST_REMA  = 4'd2;
    localparam t_addr ST_REMB  = 4'd3;
    localparam t_addr ST_DOWN  = 4'd4;
    localparam t_addr ST_DCENT = 4'd5;
    localparam t_addr ST_DADD  = 4'd6;
    localparam t_addr ST_UCENT = 4'd7;
    localparam t_addr ST_UP    = 4'd8;
    localparam t_addr ST_HOUR  = 4'd9;
    localparam t_addr ST_MS1   = 4'd10;
    localparam t_addr ST_MS2   = 4'd11;
    localparam t_addr ST_MS3   = 4'd12;
    localparam t_addr ST_MON   = 4'd13;
    localparam t_addr ST_DONE  = 4'd14;

    // Control word: when cond holds, go to jmp and skip op; otherwise run op
    // and go to nxt.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_addr jmp;
        t_addr nxt;
    } t_uword;

    typedef struct packed {
        logic load;
        logic exec;
        t_op  op;
    } t_ctl;

    typedef struct packed {
        logic rem_pos;
        logic rem_fits;
        logic mon_done;
    } t_flags;

    localparam logic [21:0] LAST_DAY    = 22'd2958464;
    localparam logic [16:0] LAST_SECOND = 17'd86399;
    localparam logic [13:0] BASE_YEAR   = 14'd1900;

    // floor(400 * 2^32 / 146097): estimate is exact or one low, loops fix it.
    localparam logic [23:0] RECIP_YEAR  = 24'd11759221;
    // ceil(2^19 / 100), exact for values below 16384.
    localparam logic [12:0] RECIP_CENT  = 13'd5243;
    // ceil(2^27 / 3600), exact below 86400.
    localparam logic [15:0] RECIP_HOUR  = 16'd37283;
    // ceil(2^20 / 60), exact below 3600.
    localparam logic [14:0] RECIP_MIN   = 15'd17477;
    // 365 * 1900 + leap days before 1900 (460).
    localparam logic [24:0] REM_BIAS    = 25'd693960;

    function automatic logic [7:0] cent_of(input logic [13:0] v);
        logic [26:0] p;
        p = 27'(v) * 27'(RECIP_CENT);
        return p[26:19];
    endfunction

    function automatic logic leap_of(input logic [13:0] y, input logic [7:0] c);
        logic [13:0] r;
        r = y - {6'b0, c} * 14'd100;
        return ((r != 14'd0) && (y[1:0] == 2'd0)) || ((r == 14'd0) && (c[1:0] == 2'd0));
    endfunction

    // Leap days in years 1..v, given c = v / 100.
    function automatic logic [13:0] leap_cnt(input logic [13:0] v, input logic [7:0] c);
        return {2'b0, v[13:2]} - {6'b0, c} + {8'b0, c[7:2]};
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/sdcd_rom.sv
// Microcode store of the calendar converter: one control word per step.
// Depends on sdcd_pkg.
`timescale 1ns / 1ps

module sdcd_rom (
    input  sdcd_pkg::t_addr  i_addr,
    output sdcd_pkg::t_uword o_word
);
    import sdcd_pkg::*;

    always_comb begin
        case (i_addr)
            ST_MULY:  o_word = '{OP_MULY, C_NONE,     ST_MULY,  ST_YEST};
            ST_YEST:  o_word = '{OP_YEST, C_NONE,     ST_YEST,  ST_REMA};
            ST_REMA:  o_word = '{OP_REMA, C_NONE,     ST_REMA,  ST_REMB};
            ST_REMB:  o_word = '{OP_REMB, C_NONE,     ST_REMB,  ST_DOWN};
            // year too high: step down until rem is positive
            ST_DOWN:  o_word = '{OP_YDEC, C_REM_POS,  ST_UCENT, ST_DCENT};
            ST_DCENT: o_word = '{OP_CENT, C_NONE,     ST_DCENT, ST_DADD};
            ST_DADD:  o_word = '{OP_YADD, C_NONE,     ST_DADD,  ST_DOWN};
            // year too low: step up until rem fits the year
            ST_UCENT: o_word = '{OP_CENT, C_NONE,     ST_UCENT, ST_UP};
            ST_UP:    o_word = '{OP_YSUB, C_REM_FITS, ST_HOUR,  ST_UCENT};
            ST_HOUR:  o_word = '{OP_HOUR, C_NONE,     ST_HOUR,  ST_MS1};
            ST_MS1:   o_word = '{OP_MS1,  C_NONE,     ST_MS1,   ST_MS2};
            ST_MS2:   o_word = '{OP_MS2,  C_NONE,     ST_MS2,   ST_MS3};
            ST_MS3:   o_word = '{OP_MS3,  C_NONE,     ST_MS3,   ST_MON};
            ST_MON:   o_word = '{OP_MSUB, C_MON_DONE, ST_DONE,  ST_MON};
            ST_DONE:  o_word = '{OP_DONE, C_NONE,     ST_DONE,  ST_MULY};
            default:  o_word = '{OP_NOP,  C_NONE,     ST_MULY,  ST_MULY};
        endcase
    end

endmodule

FILE: rtl/sdcd_seq.sv
// Step counter and jump logic of the calendar converter.
// Depends on sdcd_pkg and sdcd_rom.
`timescale 1ns / 1ps

module sdcd_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sdcd_pkg::t_flags  i_flags,
    output logic              o_busy,
    output sdcd_pkg::t_ctl    o_ctl
);
    import sdcd_pkg::*;

    logic   r_busy, n_busy;
    t_addr  r_pc, n_pc;
    t_uword word;
    logic   take;
    logic   accept;

    sdcd_rom u_rom (
        .i_addr (r_pc),
        .o_word (word)
    );

    assign accept = i_start && !r_busy;

    always_comb begin
        case (word.cond)
            C_REM_POS:  take = i_flags.rem_pos;
            C_REM_FITS: take = i_flags.rem_fits;
            C_MON_DONE: take = i_flags.mon_done;
            default:    take = 1'b0;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (accept) begin
            n_busy = 1'b1;
            n_pc   = ST_MULY;
        end else if (r_busy) begin
            n_pc = take ? word.jmp : word.nxt;
            if (!take && (word.op == OP_DONE)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= ST_MULY;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_busy     = r_busy;
    assign o_ctl.load = accept;
    assign o_ctl.exec = r_busy && !take;
    assign o_ctl.op   = word.op;

endmodule

FILE: rtl/sdcd_dp.sv
// Datapath of the calendar converter: year, remainder, month and time registers.
// Depends on sdcd_pkg.
`timescale 1ns / 1ps

module sdcd_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sdcd_pkg::t_ctl    i_ctl,
    input  sdcd_pkg::t_item   i_item,
    output sdcd_pkg::t_flags  o_flags,
    output sdcd_pkg::t_result o_result,
    output logic              o_valid
);
    import sdcd_pkg::*;

    logic [21:0] r_day;
    logic [16:0] r_sec;
    logic [45:0] r_prod;
    logic [13:0] r_year;
    logic [7:0]  r_cent;
    logic [24:0] r_rem;
    logic [3:0]  r_mon;
    logic [4:0]  r_hour;
    logic [5:0]  r_min;
    t_result     r_res;
    logic        r_valid;

    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [13:0] prev_year;
    logic [7:0]  cent_in;
    logic [32:0] hour_prod;
    logic [26:0] min_prod;

    assign leap      = leap_of(r_year, r_cent);
    assign ylen      = 9'd365 + {8'b0, leap};
    assign mlen      = month_len(r_mon, leap);
    assign prev_year = r_year - 14'd1;
    assign cent_in   = cent_of((i_ctl.op == OP_REMA) ? prev_year : r_year);
    assign hour_prod = 33'(r_sec) * 33'(RECIP_HOUR);
    assign min_prod  = 27'(r_sec[11:0]) * 27'(RECIP_MIN);

    assign o_flags.rem_pos  = !r_rem[24] && (r_rem != 25'd0);
    assign o_flags.rem_fits = $signed(r_rem) <= $signed({16'b0, ylen});
    assign o_flags.mon_done = (r_mon == 4'd12) || ($signed(r_rem) <= $signed({20'b0, mlen}));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_day <= (i_item.day_count > LAST_DAY) ? LAST_DAY : i_item.day_count;
            r_sec <= (i_item.second_of_day > LAST_SECOND) ? LAST_SECOND
                                                          : i_item.second_of_day;
        end else if (i_ctl.exec) begin
            case (i_ctl.op)
                OP_MULY: r_prod <= 46'(r_day) * 46'(RECIP_YEAR);
                OP_YEST: r_year <= r_prod[45:32] + BASE_YEAR;
                OP_REMA: begin
                    r_rem  <= 25'(r_day) + REM_BIAS - 25'(r_year) * 25'd365;
                    r_cent <= cent_in;
                end
                OP_REMB: r_rem  <= r_rem - 25'(leap_cnt(prev_year, r_cent));
                OP_YDEC: r_year <= prev_year;
                OP_CENT: r_cent <= cent_in;
                OP_YADD: r_rem  <= r_rem + 25'(ylen);
                OP_YSUB: begin
                    r_rem  <= r_rem - 25'(ylen);
                    r_year <= r_year + 14'd1;
                end
                OP_HOUR: begin
                    r_hour <= hour_prod[31:27];
                    r_mon  <= 4'd1;
                end
                OP_MS1:  r_sec <= r_sec - 17'(r_hour) * 17'd3600;
                OP_MS2:  r_min <= min_prod[25:20];
                OP_MS3:  r_sec <= r_sec - 17'(r_min) * 17'd60;
                OP_MSUB: begin
                    r_rem <= r_rem - 25'(mlen);
                    r_mon <= r_mon + 4'd1;
                end
                OP_DONE: begin
                    r_res.year         <= r_year;
                    r_res.month        <= r_mon;
                    r_res.day_of_month <= r_rem[4:0];
                    r_res.hour         <= r_hour;
                    r_res.minute       <= r_min;
                    r_res.second       <= r_sec[5:0];
                end
                default: ;
            endcase
        end
    end

    // Strobe for one cycle after the capture step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.exec && (i_ctl.op == OP_DONE);
        end
    end

    assign o_result = r_res;
    assign o_valid  = r_valid;

endmodule

FILE: rtl/serial_day_to_calendar_date.sv
// Top level of the serial day to calendar date converter.
// Depends on sdcd_pkg, sdcd_seq (with sdcd_rom) and sdcd_dp.
//
//  channel  | ports                 | handshake
//  ---------+-----------------------+-------------------------------------------
//  input    | i_item (t_item)       | transaction taken when start high, busy low
//  result   | o_result (t_result)   | o_valid high for one cycle, never stalled
//
// A microcoded sequencer runs a 15-word program over one shared datapath.
// Busy time per transaction grows with each downward year step, each upward year
// step and each month walked; the year correction and month walk loops set it.
// The result strobe rises at the edge that drops busy, and the next transaction
// may be taken in that same cycle.
// Reset (i_rst_n low, synchronous) clears busy, the step counter and the strobe.
// The receiver cannot stall; each result shows for exactly one cycle.
`timescale 1ns / 1ps

module serial_day_to_calendar_date (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sdcd_pkg::t_item   i_item,
    output logic              o_valid,
    output sdcd_pkg::t_result o_result
);
    import sdcd_pkg::*;

    t_ctl   ctl;
    t_flags flags;

    // Sequencer: holds the step counter, picks the next word, drives the ops.
    sdcd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (flags),
        .o_busy  (busy),
        .o_ctl   (ctl)
    );

    // Datapath: load the saturated item, estimate and correct the year,
    // split the seconds, walk the months, capture the result.
    sdcd_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_item   (i_item),
        .o_flags  (flags),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

endmodule

FILE: rtl/sdcd_chk.sv
// Port-level checker for the calendar converter, bound to the top level.
// Depends on sdcd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sdcd_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input sdcd_pkg::t_result o_result
);
    import sdcd_pkg::*;

    logic ranges_ok;

    assign ranges_ok = (o_result.month >= 4'd1) && (o_result.month <= 4'd12)
                    && (o_result.day_of_month != 5'd0) && (o_result.hour < 5'd24)
                    && (o_result.minute < 6'd60) && (o_result.second < 6'd60);

    // A result is shown only once the transaction has finished.
    `SDCD_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    // A taken transaction makes the block busy.
    `SDCD_ASSERT_NXT(a_take_busy, i_clk, i_rst_n, start && !busy, busy)
    // One strobe per transaction.
    `SDCD_ASSERT_NXT(a_one_strobe, i_clk, i_rst_n, o_valid, !o_valid)
    // Result fields stay within the calendar and the clock.
    `SDCD_ASSERT_IMP(a_ranges, i_clk, i_rst_n, o_valid, ranges_ok)

endmodule

bind serial_day_to_calendar_date sdcd_chk u_chk (.*);
